>>> src/page_bitmap_mosaic_assert.svh
// ----------------------------------------------------------------------------
// Page bitmap mosaic assertion macros
// Shared concurrent assertion forms, gated by the asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_MOSAIC_ASSERT_SVH
`define PAGE_BITMAP_MOSAIC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/pbm_pkg.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic package
// Shared types, constants and the in-byte block OR function.
// ----------------------------------------------------------------------------
`default_nettype none

package pbm_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;

    // Mask pairs per stage: (low half, high half) of each aligned block.
    localparam logic [7:0] STAGE_MASK [6] = '{8'h55, 8'hAA, 8'h33, 8'hCC, 8'h0F, 8'hF0};

    // One closed group: the finished byte and the level that sets its repeat count.
    typedef struct packed {
        logic [7:0] mos_byte;
        logic [1:0] level;
    } mos_entry_t;

    typedef struct packed {
        logic       push;
        mos_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic       valid;
        mos_entry_t entry;
    } q_head_t;

    // OR aligned blocks of 2^lv bits together, one mask-and-shift stage per level.
    function automatic logic [7:0] mosaic_bits(input logic [7:0] c, input logic [1:0] lv);
        logic [7:0] v;
        v = c;
        for (int j = 0; j < 3; j++) begin
            if (j < int'(lv)) begin
                v = v | ((v & STAGE_MASK[2*j]) << (1 << j))
                      | ((v & STAGE_MASK[2*j+1]) >> (1 << j));
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> src/pbm_stream_if.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic stream interfaces
// Valid/ready channels for incoming buffer bytes and outgoing mosaic bytes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pbm_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface pbm_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output out_byte, output last, input ready);
    modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

>>> src/page_bitmap_mosaic.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic
// Mosaic pixelation of a 1-bit page-ordered display buffer stream.
// ----------------------------------------------------------------------------
// The block takes buffer bytes (eight vertical pixels, bit 0 on top) on
// pixel_in and sends mosaicked bytes on mosaic_out. With level L, every 2^L
// input bytes form a group: they are ORed together, aligned blocks of 2^L bits
// inside that byte are ORed together, and the result goes out 2^L times, the
// final copy marked with last. Level 0 passes bytes straight through with last
// set on each. Both sides move one item per cycle: a byte that only extends
// a group is always taken, and a byte that closes a group is taken whenever
// the group queue (QUEUE_DEPTH entries) has room, so the input is paced only
// by the repeater, which sends one copy per cycle while the receiver is
// ready. A group's first copy passes the queue write, then the output
// register. Write level only while the block is idle; a partial group
// survives a level change and closes as soon as its count reaches the new size.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_mosaic #(
    parameter int QUEUE_DEPTH = pbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       level_we,
    input  wire logic [1:0] level_wdata,
    pbm_in_if.sink          pixel_in,
    pbm_out_if.source       mosaic_out
);

    pbm_pkg::q_push_t q_push;
    pbm_pkg::q_head_t q_head;
    logic             q_full;
    logic             q_pop;

    // Front end: gather groups, mosaic the closing byte, push it.
    pbm_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .level_we    (level_we),
        .level_wdata (level_wdata),
        .pixel_in    (pixel_in),
        .q_full      (q_full),
        .q_push      (q_push)
    );

    // Decouple the front end from the repeater.
    pbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_req (q_push),
        .full     (q_full),
        .head     (q_head),
        .pop      (q_pop)
    );

    // Back end: repeat each group's byte and flag the last copy.
    pbm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .pop        (q_pop),
        .mosaic_out (mosaic_out)
    );

endmodule

`default_nettype wire

>>> src/pbm_front.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic front end
// Holds the level register, gathers groups and pushes closed groups.
// ----------------------------------------------------------------------------
`default_nettype none

module pbm_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             level_we,
    input  wire logic [1:0]       level_wdata,
    pbm_in_if.sink                pixel_in,
    input  wire logic             q_full,
    output pbm_pkg::q_push_t      q_push
);

    logic [1:0] level_reg;
    logic [7:0] group_or_reg;
    logic [7:0] group_or_next;
    logic [2:0] group_count_reg;
    logic [2:0] group_count_next;
    logic [3:0] count_plus;
    logic [3:0] group_size;
    logic       closes;
    logic       accept;
    logic [7:0] merged;

    // A group closes once its byte count reaches the size under the current level.
    assign count_plus = {1'b0, group_count_reg} + 4'd1;
    assign group_size = 4'd1 << level_reg;
    assign closes     = (count_plus >= group_size);

    // Bytes that only extend a group never need queue space.
    assign pixel_in.ready = !closes || !q_full;
    assign accept         = pixel_in.valid && pixel_in.ready;
    assign merged         = group_or_reg | pixel_in.pixel_byte;

    always_comb
    begin
        group_or_next    = group_or_reg;
        group_count_next = group_count_reg;
        if (accept)
        begin
            if (closes)
            begin
                group_or_next    = 8'h00;
                group_count_next = 3'd0;
            end
            else
            begin
                group_or_next    = merged;
                group_count_next = count_plus[2:0];
            end
        end
    end

    assign q_push.push           = accept && closes;
    assign q_push.entry.mos_byte = pbm_pkg::mosaic_bits(merged, level_reg);
    assign q_push.entry.level    = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg       <= 2'd0;
            group_or_reg    <= 8'h00;
            group_count_reg <= 3'd0;
        end
        else
        begin
            if (level_we)
            begin
                level_reg <= level_wdata;
            end
            group_or_reg    <= group_or_next;
            group_count_reg <= group_count_next;
        end
    end

endmodule

`default_nettype wire

>>> src/pbm_queue.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic group queue
// Short FIFO of closed groups between the front end and the repeater.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_bitmap_mosaic_assert.svh"

module pbm_queue #(
    parameter int DEPTH = pbm_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbm_pkg::q_push_t push_req,
    output logic                  full,
    output pbm_pkg::q_head_t      head,
    input  wire logic             pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pbm_pkg::mos_entry_t store_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.entry = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_req.push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_req.push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push_req.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_req.push)
        begin
            store_reg[wr_ptr_reg] <= push_req.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `PBM_ASSERT_IMP(a_no_overflow, clk, rst_n, push_req.push, !full || pop, "queue overflow")
    `PBM_ASSERT_IMP(a_no_underflow, clk, rst_n, pop, count_reg != '0, "queue underflow")

endmodule

`default_nettype wire

>>> src/pbm_back.sv
// ----------------------------------------------------------------------------
// Page bitmap mosaic repeater
// Emits each closed group's byte 2^level times and flags the last copy.
// ----------------------------------------------------------------------------
`default_nettype none

`include "page_bitmap_mosaic_assert.svh"

module pbm_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pbm_pkg::q_head_t head,
    output logic                  pop,
    pbm_out_if.source             mosaic_out
);

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_byte_reg;
    logic [7:0] out_byte_next;
    logic       last_reg;
    logic       last_next;
    logic [2:0] rem_reg;
    logic [2:0] rem_next;
    logic       advance;
    logic       repeating;
    logic [3:0] head_size;
    logic [3:0] head_size_m1;

    assign advance      = !out_valid_reg || mosaic_out.ready;
    assign repeating    = out_valid_reg && (rem_reg != 3'd0);
    assign pop          = advance && !repeating && head.valid;
    assign head_size    = 4'd1 << head.entry.level;
    assign head_size_m1 = head_size - 4'd1;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        if (advance)
        begin
            if (repeating)
            begin
                rem_next  = rem_reg - 3'd1;
                last_next = (rem_reg == 3'd1);
            end
            else if (head.valid)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = head.entry.mos_byte;
                rem_next       = head_size_m1[2:0];
                last_next      = (head_size_m1 == 4'd0);
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            rem_reg       <= 3'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            rem_reg       <= rem_next;
        end
    end

    assign mosaic_out.valid    = out_valid_reg;
    assign mosaic_out.out_byte = out_byte_reg;
    assign mosaic_out.last     = last_reg;

    `PBM_ASSERT_IMP(a_last_ends_run, clk, rst_n, out_valid_reg && last_reg,
                    rem_reg == 3'd0, "last with copies left")
    `PBM_ASSERT_IMP(a_run_has_tail, clk, rst_n, out_valid_reg && !last_reg,
                    rem_reg != 3'd0, "run ends without last")
    `PBM_ASSERT_NXT(a_pop_shows, clk, rst_n, pop, out_valid_reg, "popped group not shown")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page bitmap mosaic testbench
// Streams buffer bytes into the mosaic block under all four levels, predicts
// every repeated output byte and its last flag, and checks them in order
// while both channel ends idle, stall and, once, hold off for a long stretch.
// ----------------------------------------------------------------------------

module testbench;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 8;     // settle time after the last output copy
    localparam int HOLD_CYCLES = 150;     // long receiver hold-off
    localparam int REPORT_LIMIT = 10;

    // One predicted copy on the output channel.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } mos_copy_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       level_we = 1'b0;
    logic [1:0] level_wdata = 2'd0;

    // Testbench-side drivers of the channel signals, known from time zero.
    logic       src_valid = 1'b0;
    logic [7:0] src_byte = 8'h00;
    logic       sink_ready = 1'b0;
    logic       in_fire = 1'b0;

    pbm_in_if  in_ch ();
    pbm_out_if out_ch ();

    assign in_ch.valid      = src_valid;
    assign in_ch.pixel_byte = src_byte;
    assign out_ch.ready     = sink_ready;

    page_bitmap_mosaic dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .level_we    (level_we),
        .level_wdata (level_wdata),
        .pixel_in    (in_ch),
        .mosaic_out  (out_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // Bytes waiting to be offered, and the copies the block still owes us.
    logic [7:0] pending_bytes [$];
    mos_copy_t  mosaic_due [$];

    // Shadow of the level register and of the partial group.
    logic [1:0] level_shadow = 2'd0;
    logic [7:0] group_acc = 8'h00;
    logic [2:0] group_fill = 3'd0;

    int fail_count = 0;

    // Idle knobs, set per phase by the sequencer.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long hold-off handshake between the sequencer and the receiver.
    logic long_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_cnt = 0;

    // OR every aligned block of 2^lv bits and spread the result over that
    // block; level 0 leaves the byte alone.
    function automatic logic [7:0] spread_blocks(input logic [7:0] b, input logic [1:0] lv);
        int         w;
        logic [7:0] r;
        logic [7:0] m;
        w = 1 << lv;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            m = 8'((1 << w) - 1) << ((i / w) * w);
            r[i] = |(b & m);
        end
        return r;
    endfunction

    // Fold one accepted byte into the group; when the group is full under
    // the current level, queue its byte 2^level times, last on the final one.
    task automatic gather_byte(input logic [7:0] b);
        int         size;
        int         count;
        logic [7:0] v;
        mos_copy_t  cp;
        size = 1 << level_shadow;
        count = int'(group_fill) + 1;
        group_acc = group_acc | b;
        if (count < size)
        begin
            group_fill = count[2:0];
        end
        else
        begin
            v = spread_blocks(group_acc, level_shadow);
            for (int k = 0; k < size; k++)
            begin
                cp.out_byte = v;
                cp.last = (k == size - 1);
                mosaic_due.push_back(cp);
            end
            group_acc = 8'h00;
            group_fill = 3'd0;
        end
    endtask

    // Sample the input handshake at the rising edge and predict from it.
    always @(posedge clk)
    begin : input_monitor
        in_fire <= rst_n && src_valid && in_ch.ready;
        if (rst_n && src_valid && in_ch.ready)
        begin
            gather_byte(src_byte);
        end
    end

    // Offer the next pending byte at the falling edge. Hold the current one
    // until it has been taken; drop valid only when the sender goes idle.
    always @(negedge clk)
    begin : byte_driver
        if (rst_n && (!src_valid || in_fire))
        begin
            if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                src_byte <= pending_bytes.pop_front();
                src_valid <= 1'b1;
            end
            else
            begin
                src_valid <= 1'b0;
            end
        end
    end

    // Drive ready at the falling edge: random stalls, or a counted hold-off
    // while the sequencer asks for one.
    always @(negedge clk)
    begin : ready_driver
        if (!rst_n)
        begin
            sink_ready <= 1'b0;
        end
        else if (long_hold && !hold_done)
        begin
            sink_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt + 1 >= HOLD_CYCLES)
                hold_done <= 1'b1;
        end
        else
        begin
            if (!long_hold)
            begin
                hold_done <= 1'b0;
                hold_cnt <= 0;
            end
            sink_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each accepted output item with the oldest predicted copy.
    always @(posedge clk)
    begin : result_check
        mos_copy_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (mosaic_due.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("unexpected output: out_byte %02h last %b",
                             out_ch.out_byte, out_ch.last);
            end
            else
            begin
                want = mosaic_due.pop_front();
                if (out_ch.out_byte !== want.out_byte || out_ch.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("mismatch: out_byte %02h (want %02h) last %b (want %b)",
                                 out_ch.out_byte, want.out_byte, out_ch.last, want.last);
                end
            end
        end
    end

    // Wait until every queued byte is taken and every copy has come out,
    // then let the pipeline settle so a partial group is really parked.
    task automatic await_idle();
        while (pending_bytes.size() != 0 || src_valid)
            @(posedge clk);
        while (mosaic_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the level register; only called while the block is idle.
    task automatic write_level(input logic [1:0] v);
        @(negedge clk);
        level_we <= 1'b1;
        level_wdata <= v;
        @(negedge clk);
        level_we <= 1'b0;
        level_shadow = v;
    endtask

    // Mix of dense, single-pixel, blank and sparse bytes so the block OR
    // sees both empty and partly lit blocks.
    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 4))
            0:       b = 8'($urandom_range(0, 255));
            1:       b = 8'h01 << $urandom_range(0, 7);
            2:       b = 8'h00;
            3:       b = 8'($urandom_range(0, 255)) & 8'($urandom_range(0, 255))
                         & 8'($urandom_range(0, 255));
            default: b = 8'hFF;
        endcase
        return b;
    endfunction

    // Timeout: far beyond the slowest legal run.
    initial
    begin : watchdog
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : sequencer
        logic [1:0] phase_levels [8];
        int         n_items;
        int         mode;
        phase_levels = '{2'd3, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd1, 2'd2};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: pass-through extremes at the reset level.
        pending_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h5A};
        await_idle();

        // 2x2: a single corner pixel in each of two groups.
        write_level(2'd1);
        pending_bytes = '{8'h01, 8'h00, 8'h00, 8'h80};
        await_idle();

        // 4x4: one pixel lights its half, the other half stays dark.
        write_level(2'd2);
        pending_bytes = '{8'h00, 8'h02, 8'h00, 8'h00};
        await_idle();

        // 8x8: a single pixel in the last byte lights the whole byte.
        write_level(2'd3);
        pending_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h10};
        await_idle();

        // Level change mid-group: park three bytes at 8x8, drop to 2x2, and
        // the next byte closes the group since the count already exceeds two.
        pending_bytes = '{8'h04, 8'h00, 8'h20};
        await_idle();
        write_level(2'd1);
        pending_bytes = '{8'h00};
        await_idle();

        // Random phases; item counts are not always group multiples, so partial
        // groups can carry across level changes too.
        for (int p = 0; p < 8; p++)
        begin
            write_level(phase_levels[p]);
            mode = p % 4;
            send_idle_pct = (mode == 1) ? 46 : (mode == 3) ? 8 : 0;
            recv_stall_pct = (mode == 2) ? 46 : (mode == 3) ? 8 : 0;
            // Long hold-off on one phase with a busy sender to fill the queue.
            if (p == 4)
                long_hold = 1'b1;
            n_items = $urandom_range(50, 65);
            for (int i = 0; i < n_items; i++)
                pending_bytes.push_back(pick_byte());
            await_idle();
            long_hold = 1'b0;
        end

        // Close any parked group at level 0 and drain.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_level(2'd0);
        pending_bytes = '{8'($urandom_range(0, 255))};
        await_idle();
        repeat (20) @(posedge clk);

        if (mosaic_due.size() != 0)
            fail_count++;
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
